>>> src/ipv4ocf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4ocf_pkg
// Shared types, option codes and helpers for the IPv4 option copy filter.
// ----------------------------------------------------------------------------
package ipv4ocf_pkg;

  // Largest option area accepted; longer lengths saturate to this
  localparam logic [5:0] MAX_OPTION_BYTES = 6'd40;

  // Most result words one input word can cause (type, length, pad)
  localparam int MAX_RESULTS = 3;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

  // Option type codes and masks
  localparam logic [7:0] OPT_END       = 8'h00;
  localparam logic [7:0] OPT_NOP       = 8'h01;
  localparam logic [7:0] OPT_COPY_MASK = 8'h80;
  localparam logic [7:0] MIN_OPT_LEN   = 8'd2;
  localparam logic [1:0] CNT_MASK      = 2'h3;

  typedef enum logic [1:0] {
    MODE_TYPE = 2'd0,
    MODE_LEN  = 2'd1,
    MODE_BODY = 2'd2,
    MODE_STOP = 2'd3
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] opt_byte;
    logic [5:0] area_length;
    logic       first_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       is_pad;
    logic       area_done;
    logic       run_last;
  } out_word_t;

  // Result words caused by one input word, in delivery order
  typedef struct packed {
    out_word_t [MAX_RESULTS-1:0] slot;
    logic [RES_CNT_W-1:0]        count;
  } burst_t;

  function automatic out_word_t make_word(input logic [7:0] b, input logic valid,
                                          input logic pad);
    out_word_t w;
    w.out_byte   = b;
    w.byte_valid = valid;
    w.is_pad     = pad;
    w.area_done  = 1'b0;
    w.run_last   = 1'b0;
    return w;
  endfunction

endpackage
`default_nettype wire

>>> src/ipv4ocf_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4ocf_in_if
// Option byte channel: valid/ready handshake with one option area byte.
// ----------------------------------------------------------------------------
interface ipv4ocf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opt_byte;
  logic [5:0] area_length;
  logic       first_byte;

  modport source (output valid, opt_byte, area_length, first_byte, input ready);
  modport sink   (input valid, opt_byte, area_length, first_byte, output ready);
endinterface
`default_nettype wire

>>> src/ipv4ocf_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4ocf_out_if
// Copied byte channel: valid/ready handshake with one filtered result.
// ----------------------------------------------------------------------------
interface ipv4ocf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       is_pad;
  logic       area_done;
  logic       run_last;

  modport source (output valid, out_byte, byte_valid, is_pad, area_done, run_last,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, is_pad, area_done, run_last,
                  output ready);
endinterface
`default_nettype wire

>>> src/ipv4ocf_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4ocf_parser
// Option parse state and per-byte decode: turns one area byte into the
// result words it causes and advances the parse state when told to.
// ----------------------------------------------------------------------------
module ipv4ocf_parser (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                advance,
  input  wire ipv4ocf_pkg::in_word_t word,
  output ipv4ocf_pkg::burst_t       burst
);
  import ipv4ocf_pkg::*;

  // Parse state
  logic [5:0]  bytes_remaining, bytes_remaining_next;
  logic [5:0]  option_left, option_left_next;
  parse_mode_t parse_mode, parse_mode_next;
  logic [7:0]  held_type, held_type_next;
  logic        copy_current, copy_current_next;
  logic [1:0]  copied_count_low, copied_count_low_next;

  // State as seen by this byte, after a possible area restart
  logic [5:0]  eff_br, eff_ol, alen;
  parse_mode_t eff_md;
  logic [7:0]  eff_ht;
  logic        eff_cc;
  logic [1:0]  eff_cnt;
  logic        len_ok;
  logic [1:0]  nvalid;

  // Restart the area on a first byte; clamp the area length
  always_comb begin
    alen = word.area_length;
    if (alen == 6'd0) begin
      alen = 6'd1;
    end else if (alen > MAX_OPTION_BYTES) begin
      alen = MAX_OPTION_BYTES;
    end
    eff_br  = bytes_remaining;
    eff_ol  = option_left;
    eff_md  = parse_mode;
    eff_ht  = held_type;
    eff_cc  = copy_current;
    eff_cnt = copied_count_low;
    if (word.first_byte) begin
      eff_br  = alen;
      eff_ol  = 6'd0;
      eff_md  = MODE_TYPE;
      eff_ht  = 8'd0;
      eff_cc  = 1'b0;
      eff_cnt = 2'd0;
    end
  end

  // Length byte must be at least 2 and fit in the area from the type byte on
  assign len_ok = (word.opt_byte >= MIN_OPT_LEN) &&
                  ({1'b0, word.opt_byte} <= ({3'b000, eff_br} + 9'd1));

  // Next parse state
  always_comb begin
    bytes_remaining_next = eff_br;
    option_left_next     = eff_ol;
    parse_mode_next      = eff_md;
    held_type_next       = eff_ht;
    copy_current_next    = eff_cc;
    if (eff_br != 6'd0) begin
      bytes_remaining_next = eff_br - 6'd1;
      unique case (eff_md)
        MODE_TYPE: begin
          if (word.opt_byte == OPT_END) begin
            parse_mode_next = MODE_STOP;
          end else if (word.opt_byte == OPT_NOP) begin
            parse_mode_next = MODE_TYPE;
          end else if (eff_br < 6'd2) begin
            parse_mode_next = MODE_STOP;
          end else begin
            held_type_next    = word.opt_byte;
            copy_current_next = (word.opt_byte & OPT_COPY_MASK) != 8'd0;
            parse_mode_next   = MODE_LEN;
          end
        end
        MODE_LEN: begin
          if (!len_ok) begin
            parse_mode_next = MODE_STOP;
          end else begin
            option_left_next = 6'(word.opt_byte - MIN_OPT_LEN);
            parse_mode_next  = (option_left_next != 6'd0) ? MODE_BODY : MODE_TYPE;
          end
        end
        MODE_BODY: begin
          option_left_next = eff_ol - 6'd1;
          if (option_left_next == 6'd0) begin
            parse_mode_next = MODE_TYPE;
          end
        end
        MODE_STOP: begin
          parse_mode_next = MODE_STOP;
        end
        default: begin
          parse_mode_next = MODE_STOP;
        end
      endcase
    end
    copied_count_low_next = (eff_cnt + nvalid) & CNT_MASK;
  end

  // Result words for this byte
  always_comb begin
    logic [RES_CNT_W-1:0] n;
    logic [1:0]           cnt_after;
    n         = '0;
    cnt_after = 2'd0;
    nvalid    = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      burst.slot[i] = make_word(8'd0, 1'b0, 1'b0);
    end
    if (eff_br != 6'd0) begin
      case (eff_md)
        MODE_TYPE: begin
          if (word.opt_byte == OPT_NOP) begin
            burst.slot[RES_IDX_W'(n)] = make_word(word.opt_byte, 1'b1, 1'b0);
            n = n + 1'b1;
          end
        end
        MODE_LEN: begin
          if (len_ok && eff_cc) begin
            burst.slot[RES_IDX_W'(n)] = make_word(eff_ht, 1'b1, 1'b0);
            n = n + 1'b1;
            burst.slot[RES_IDX_W'(n)] = make_word(word.opt_byte, 1'b1, 1'b0);
            n = n + 1'b1;
          end
        end
        MODE_BODY: begin
          if (eff_cc) begin
            burst.slot[RES_IDX_W'(n)] = make_word(word.opt_byte, 1'b1, 1'b0);
            n = n + 1'b1;
          end
        end
        default: begin
        end
      endcase
      cnt_after = (eff_cnt + 2'(n)) & CNT_MASK;
      nvalid    = 2'(n);
      // Close the area: add one end-of-list pad byte if the copied count is not a 4-byte multiple, and mark the end
      if (eff_br == 6'd1) begin
        if (cnt_after != 2'd0) begin
          burst.slot[RES_IDX_W'(n)] = make_word(OPT_END, 1'b1, 1'b1);
          n      = n + 1'b1;
          nvalid = nvalid + 2'd1;
        end
        if (n == '0) begin
          burst.slot[RES_IDX_W'(n)] = make_word(8'd0, 1'b0, 1'b0);
          n = n + 1'b1;
        end
        burst.slot[RES_IDX_W'(n - 1'b1)].area_done = 1'b1;
      end
      if (n != '0) begin
        burst.slot[RES_IDX_W'(n - 1'b1)].run_last = 1'b1;
      end
    end
    burst.count = n;
  end

  // Hold or advance the parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining  <= 6'd0;
      option_left      <= 6'd0;
      parse_mode       <= MODE_TYPE;
      held_type        <= 8'd0;
      copy_current     <= 1'b0;
      copied_count_low <= 2'd0;
    end else if (advance) begin
      bytes_remaining  <= bytes_remaining_next;
      option_left      <= option_left_next;
      parse_mode       <= parse_mode_next;
      held_type        <= held_type_next;
      copy_current     <= copy_current_next;
      copied_count_low <= copied_count_low_next;
    end
  end

endmodule
`default_nettype wire

>>> src/ipv4_option_copy_filter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_option_copy_filter_unit
// Filters an IPv4 option area byte by byte and passes on NOPs and the options
// repeated in later fragments, plus one end-of-list pad byte when unaligned.
// ----------------------------------------------------------------------------
//  Channel        Dir  Word
//  option_bytes   in   opt_byte[8], area_length[6], first_byte
//  copied_bytes   out  out_byte[8], byte_valid, is_pad, area_done, run_last
//
//  One option byte can be taken every cycle. A byte is held in the input
//  register, then loads its 0 to 3 result words into the result slots,
//  which drain one word per cycle; a byte that causes two or three words
//  stalls the input side while they drain, if the next byte has results.
//  Reset (rst, synchronous) clears the parse state and empties both stages.
//  A stall on copied_bytes backs up into option_bytes.ready in the same cycle.
// ----------------------------------------------------------------------------
module ipv4_option_copy_filter_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  ipv4ocf_in_if.sink   option_bytes,
  ipv4ocf_out_if.source copied_bytes
);
  import ipv4ocf_pkg::*;

  // Input register
  logic     s1_valid;
  in_word_t s1_word;

  // Result slots
  out_word_t            res_slot [MAX_RESULTS];
  logic [RES_IDX_W-1:0] res_ptr;
  logic [RES_CNT_W-1:0] res_left;

  burst_t burst;
  logic   res_free;
  logic   s1_move;
  logic   res_load;
  logic   out_take;
  logic   in_take;

  ipv4ocf_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_move),
    .word    (s1_word),
    .burst   (burst)
  );

  // Handshake control
  assign out_take = copied_bytes.valid && copied_bytes.ready;
  assign res_free = (res_left == '0) ||
                    ((res_left == RES_CNT_W'(1)) && copied_bytes.ready);
  assign s1_move  = s1_valid && ((burst.count == '0) || res_free);
  assign res_load = s1_move && (burst.count != '0);
  assign option_bytes.ready = !s1_valid || s1_move;
  assign in_take  = option_bytes.valid && option_bytes.ready;

  // Capture the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (option_bytes.ready) begin
      s1_valid <= option_bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word.opt_byte    <= option_bytes.opt_byte;
      s1_word.area_length <= option_bytes.area_length;
      s1_word.first_byte  <= option_bytes.first_byte;
    end
  end

  // Load a burst of results, or advance through the one held
  always_ff @(posedge clk) begin
    if (rst) begin
      res_ptr  <= '0;
      res_left <= '0;
    end else if (res_load) begin
      res_ptr  <= '0;
      res_left <= burst.count;
    end else if (out_take) begin
      res_ptr  <= res_ptr + 1'b1;
      res_left <= res_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res_slot[i] <= burst.slot[i];
      end
    end
  end

  // Drive the output word
  assign copied_bytes.valid      = (res_left != '0);
  assign copied_bytes.out_byte   = res_slot[res_ptr].out_byte;
  assign copied_bytes.byte_valid = res_slot[res_ptr].byte_valid;
  assign copied_bytes.is_pad     = res_slot[res_ptr].is_pad;
  assign copied_bytes.area_done  = res_slot[res_ptr].area_done;
  assign copied_bytes.run_last   = res_slot[res_ptr].run_last;

`ifndef SYNTHESIS
  // A stalled word keeps its slot
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    copied_bytes.valid && !copied_bytes.ready |=> $stable(res_ptr))
    else $error("result pointer moved during stall");

  // The end of an area is also the last word of its byte
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    copied_bytes.valid && copied_bytes.area_done |-> copied_bytes.run_last)
    else $error("area_done without run_last");

  // The pad word is a valid end-of-list byte
  a_pad_form: assert property (@(posedge clk) disable iff (rst)
    copied_bytes.valid && copied_bytes.is_pad |->
      copied_bytes.byte_valid && (copied_bytes.out_byte == OPT_END))
    else $error("malformed pad word");

  // A new burst never overwrites words still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (res_left == '0) || ((res_left == RES_CNT_W'(1)) && out_take))
    else $error("result burst loaded over pending words");
`endif

endmodule
`default_nettype wire
